[rtl/pressure_temperature_compensation_core_assert.svh]
// Assertion macros for the compensation core
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_ASSERT_SVH
`define PTC_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PTC_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/ptc_pkg.sv]
`timescale 1ns / 1ps
package ptc_pkg;
    localparam int W = 32;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 64;
    localparam logic [CfgIdxW-1:0] REG_TCAL = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PLOW = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PHIGH = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_P9 = 2'd3;
    localparam logic OP_TEMP = 1'b0;
    localparam logic OP_PRESS = 1'b1;
    typedef struct packed {
        logic start;
        logic [W-1:0] num;
        logic [W-1:0] den;
    } div_req_t;
    typedef struct packed {
        logic busy;
        logic done;
        logic [W-1:0] quo;
    } div_rsp_t;
    function automatic logic [W-1:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction
    function automatic logic [W-1:0] asr(input logic [W-1:0] a, input logic [4:0] n);
        return W'($signed(a) >>> n);
    endfunction
endpackage

[rtl/pressure_temperature_compensation_core.sv]
`timescale 1ns / 1ps
// Barometric temperature/pressure compensation core.
// s_axis: one beat per raw reading; tuser = op (0 temperature, 1 pressure),
// tdata = raw_reading in bits 19:0. m_axis: one beat per reading;
// tdata = result_value in bits 31:0, tuser = error.
// Calibration is written via cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, the block does not enforce this. A shared
// 32x32 wrapping multiply/add unit is stepped by a sequencer, one
// operation per cycle except while the pressure quotient comes from a
// radix-2 divider; a zero divisor skips the divider.
// One reading is processed at a time; s_axis_tready is low while busy or
// while a result waits, so the next reading can be accepted in the cycle
// after the result beat is taken.
// A stalled m_axis holds its beat; the next reading is accepted after the
// beat is taken. Reset clears calibration, fine temperature and output.
module pressure_temperature_compensation_core
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [23:0] s_axis_tdata, // raw_reading[19:0], zero fill
    input  logic s_axis_tuser,        // op
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [31:0] m_axis_tdata, // result_value[31:0]
    output logic m_axis_tuser,        // error
    input  logic cfg_we,
    input  logic [ptc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [ptc_pkg::CfgDataW-1:0] cfg_data
);
    import ptc_pkg::*;
`include "pressure_temperature_compensation_core_assert.svh"
    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_P10, S_P11, S_DIV, S_DWAIT, S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_OUT
    } state_t;
    state_t st_reg;
    logic [47:0] tcal_reg;
    logic [63:0] plow_reg, phigh_reg;
    logic [15:0] p9_reg;
    logic [W-1:0] ft_reg, a_reg, b_reg, c_reg, x_reg, adc_reg;
    logic [W-1:0] res_reg;
    logic err_reg, vld_reg, op_reg;
    logic [W-1:0] ma, mb, ad, mout;
    div_req_t dreq;
    div_rsp_t drsp;
    logic [W-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, tcal_reg[15:0]};
    assign t2 = sx16(tcal_reg[31:16]);
    assign t3 = sx16(tcal_reg[47:32]);
    assign p1 = {16'd0, plow_reg[15:0]};
    assign p2 = sx16(plow_reg[31:16]);
    assign p3 = sx16(plow_reg[47:32]);
    assign p4 = sx16(plow_reg[63:48]);
    assign p5 = sx16(phigh_reg[15:0]);
    assign p6 = sx16(phigh_reg[31:16]);
    assign p7 = sx16(phigh_reg[47:32]);
    assign p8 = sx16(phigh_reg[63:48]);
    assign p9 = sx16(p9_reg);
    // shared unit: mout = ma*mb + ad (wrapping)
    always_comb
    begin
        ma = '0;
        mb = '0;
        ad = '0;
        unique case (st_reg)
            S_T0: begin ma = (adc_reg >> 3) - (t1 << 1); mb = t2; end
            S_T1: begin ma = (adc_reg >> 4) - t1; mb = ma; end
            S_T2: begin ma = asr(b_reg, 5'd12); mb = t3; end
            S_T3: begin ma = 32'd1; mb = asr(a_reg, 5'd11); ad = asr(b_reg, 5'd14); end
            S_T4: begin ma = x_reg; mb = 32'd5; ad = 32'd128; end
            S_P0: begin ma = asr(ft_reg, 5'd1); mb = 32'd1; ad = -32'd64000; end
            S_P1: begin ma = asr(a_reg, 5'd2); mb = ma; end
            S_P2: begin ma = asr(b_reg, 5'd11); mb = p6; end
            S_P3: begin ma = a_reg; mb = p5; end
            S_P4: begin ma = x_reg << 1; mb = 32'd1; ad = c_reg; end
            S_P5: begin ma = p3; mb = asr(b_reg, 5'd13); end
            S_P6: begin ma = p2; mb = a_reg; end
            S_P7: begin ma = 32'd1; mb = asr(x_reg, 5'd1); ad = asr(b_reg, 5'd3); end
            S_P8: begin ma = 32'd32768 + asr(x_reg, 5'd18); mb = p1; end
            S_P9: begin ma = 32'd1; mb = asr(c_reg, 5'd2); ad = p4 << 16; end
            S_P10: begin ma = 32'd1048576 - adc_reg - asr(c_reg, 5'd12); mb = 32'd3125; end
            S_Q0: begin ma = x_reg >> 3; mb = ma; end
            S_Q1: begin ma = p9; mb = b_reg >> 13; end
            S_Q2: begin ma = x_reg >> 2; mb = p8; end
            S_Q3: begin ma = 32'd1; mb = asr(b_reg, 5'd12); ad = asr(c_reg, 5'd13) + p7; end
            S_Q4: begin ma = 32'd1; mb = x_reg; ad = asr(c_reg, 5'd4); end
            default: ;
        endcase
        mout = W'(ma * mb) + ad;
    end
    assign dreq.start = (st_reg == S_DIV);
    assign dreq.num = c_reg[W-1] ? c_reg : (c_reg << 1);
    assign dreq.den = a_reg;
    ptc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
    assign s_axis_tready = (st_reg == S_IDLE) && !vld_reg;
    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata = res_reg;
    assign m_axis_tuser = err_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            tcal_reg <= '0;
            plow_reg <= '0;
            phigh_reg <= '0;
            p9_reg <= '0;
            ft_reg <= '0;
            vld_reg <= 1'b0;
            err_reg <= 1'b0;
            res_reg <= '0;
            op_reg <= OP_TEMP;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TCAL: tcal_reg <= cfg_data[47:0];
                    REG_PLOW: plow_reg <= cfg_data;
                    REG_PHIGH: phigh_reg <= cfg_data;
                    REG_P9: p9_reg <= cfg_data[15:0];
                endcase
            end
            if (vld_reg && m_axis_tready)
                vld_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg <= s_axis_tuser;
                        st_reg <= (s_axis_tuser == OP_PRESS) ? S_P0 : S_T0;
                    end
                S_T0: st_reg <= S_T1;
                S_T1: st_reg <= S_T2;
                S_T2: st_reg <= S_T3;
                S_T3: begin ft_reg <= mout; st_reg <= S_T4; end
                S_T4: begin res_reg <= asr(mout, 5'd8); err_reg <= 1'b0; st_reg <= S_OUT; end
                S_P0: st_reg <= S_P1;
                S_P1: st_reg <= S_P2;
                S_P2: st_reg <= S_P3;
                S_P3: st_reg <= S_P4;
                S_P4: st_reg <= S_P5;
                S_P5: st_reg <= S_P6;
                S_P6: st_reg <= S_P7;
                S_P7: st_reg <= S_P8;
                S_P8: st_reg <= S_P9;
                S_P9: st_reg <= S_P10;
                S_P10:
                    if (a_reg == '0)
                    begin
                        res_reg <= '0;
                        err_reg <= 1'b1;
                        st_reg <= S_OUT;
                    end
                    else
                        st_reg <= S_P11;
                S_P11: st_reg <= S_DIV;
                S_DIV: st_reg <= S_DWAIT;
                S_DWAIT: if (drsp.done) st_reg <= S_Q0;
                S_Q0: st_reg <= S_Q1;
                S_Q1: st_reg <= S_Q2;
                S_Q2: st_reg <= S_Q3;
                S_Q3: st_reg <= S_Q4;
                S_Q4: begin res_reg <= mout; err_reg <= 1'b0; st_reg <= S_OUT; end
                S_OUT: begin vld_reg <= 1'b1; st_reg <= S_IDLE; end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
    // a: primary, b: product, c: accumulator, x: saved
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE: adc_reg <= {12'd0, s_axis_tdata[19:0]};
            S_T0: a_reg <= mout;
            S_T1: b_reg <= mout;
            S_T2: b_reg <= mout;
            S_T3: x_reg <= mout;
            S_P0: a_reg <= mout;
            S_P1: b_reg <= mout;
            S_P2: c_reg <= mout;
            S_P3: x_reg <= mout;
            S_P4: c_reg <= mout;
            S_P5: b_reg <= mout;
            S_P6: x_reg <= mout;
            S_P7: x_reg <= mout;
            S_P8: a_reg <= asr(mout, 5'd15);
            S_P9: c_reg <= mout;
            S_P10: c_reg <= mout;
            S_DWAIT: x_reg <= c_reg[W-1] ? (drsp.quo << 1) : drsp.quo;
            S_Q0: b_reg <= mout;
            S_Q1: b_reg <= mout;
            S_Q2: c_reg <= mout;
            S_Q3: c_reg <= mout;
            default: ;
        endcase
    end
    `PTC_ASSERT_IMP(a_rdy_idle, s_axis_tready, st_reg == S_IDLE && !vld_reg)
    `PTC_ASSERT_NXT(a_out_vld, st_reg == S_OUT, m_axis_tvalid)
    `PTC_ASSERT_IMP(a_div_wait, st_reg == S_DWAIT && !drsp.done, drsp.busy)
    `PTC_ASSERT_IMP(a_temp_noerr, m_axis_tvalid && op_reg == OP_TEMP, !m_axis_tuser)
endmodule

[rtl/ptc_divider.sv]
`timescale 1ns / 1ps
module ptc_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptc_pkg::div_req_t req,
    output ptc_pkg::div_rsp_t rsp
);
    import ptc_pkg::*;
    logic [W-1:0] rem_reg, rem_next, quo_reg, quo_next, den_reg;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [W:0] trial;
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next = '0;
            quo_next = req.num;
            cnt_next = 6'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
            den_reg <= req.den;
    end
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;
endmodule

[test/ptc_scoreboard.sv]
`timescale 1ns / 1ps
module ptc_scoreboard
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    input  logic s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic s_axis_tuser,
    input  logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic m_axis_tuser,
    input  logic cfg_we,
    input  logic [ptc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [ptc_pkg::CfgDataW-1:0] cfg_data,
    output int errors,
    output int pending,
    output int results_seen,
    output int div_zero_seen
);
    import ptc_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        err;
    } reading_t;

    logic [47:0] tcal;
    logic [63:0] plow;
    logic [63:0] phigh;
    logic [15:0] p9cal;
    logic [31:0] t_fine;
    reading_t compensated_q[$];

    function automatic logic [31:0] sar(input logic [31:0] a, input int n);
        return $signed(a) >>> n;
    endfunction

    function automatic logic [31:0] se(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic reading_t compensate(input logic is_press, input logic [19:0] raw);
        reading_t r;
        logic [31:0] adc, t1, t2, t3, d, a, b, q, sq, p;
        logic [31:0] c1, c2, c3, c4, c5, c6, c7, c8, c9;
        adc = {12'd0, raw};
        r.err = 1'b0;
        if (!is_press)
        begin
            t1 = {16'd0, tcal[15:0]};
            t2 = se(tcal[31:16]);
            t3 = se(tcal[47:32]);
            a = sar(((adc >> 3) - (t1 << 1)) * t2, 11);
            d = (adc >> 4) - t1;
            b = sar(sar(d * d, 12) * t3, 14);
            t_fine = a + b;
            r.value = sar(t_fine * 5 + 32'd128, 8);
            return r;
        end
        c1 = {16'd0, plow[15:0]};
        c2 = se(plow[31:16]);
        c3 = se(plow[47:32]);
        c4 = se(plow[63:48]);
        c5 = se(phigh[15:0]);
        c6 = se(phigh[31:16]);
        c7 = se(phigh[47:32]);
        c8 = se(phigh[63:48]);
        c9 = se(p9cal);
        a = sar(t_fine, 1) - 32'd64000;
        q = sar(a, 2);
        sq = q * q;
        b = sar(sq, 11) * c6;
        b = b + ((a * c5) << 1);
        b = sar(b, 2) + (c4 << 16);
        a = sar(sar(c3 * sar(sq, 13), 3) + sar(c2 * a, 1), 18);
        a = sar((32'd32768 + a) * c1, 15);
        if (a == 0)
        begin
            r.err = 1'b1;
            r.value = '0;
            return r;
        end
        p = ((32'd1048576 - adc) - sar(b, 12)) * 32'd3125;
        if (p < 32'h8000_0000)
            p = (p << 1) / a;
        else
            p = (p / a) * 2;
        a = sar(c9 * (((p >> 3) * (p >> 3)) >> 13), 12);
        b = sar((p >> 2) * c8, 13);
        r.value = p + sar(a + b + c7, 4);
        return r;
    endfunction

    assign pending = compensated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        reading_t got, want;
        if (!rst_n)
        begin
            tcal <= '0;
            plow <= '0;
            phigh <= '0;
            p9cal <= '0;
            t_fine = '0;
            compensated_q.delete();
            errors <= 0;
            results_seen <= 0;
            div_zero_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TCAL: tcal <= cfg_data[47:0];
                    REG_PLOW: plow <= cfg_data;
                    REG_PHIGH: phigh <= cfg_data;
                    REG_P9: p9cal <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value = m_axis_tdata;
                got.err = m_axis_tuser;
                results_seen <= results_seen + 1;
                if (got.err)
                    div_zero_seen <= div_zero_seen + 1;
                if (compensated_q.size() == 0)
                begin
                    $display("%0t: unexpected beat value=%h err=%b", $time, got.value,
                        got.err);
                    errors <= errors + 1;
                end
                else
                begin
                    want = compensated_q.pop_front();
                    if (got.value !== want.value || got.err !== want.err)
                    begin
                        $display("%0t: mismatch expected value=%h err=%b actual value=%h err=%b",
                            $time, want.value, want.err, got.value, got.err);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                compensated_q.push_back(compensate(s_axis_tuser, s_axis_tdata[19:0]));
        end
    end
endmodule

[test/tb_pressure_temperature_compensation_core.sv]
`timescale 1ns / 1ps
module tb_pressure_temperature_compensation_core;
    import ptc_pkg::*;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    int errors, pending, results_seen, div_zero_seen;
    int readings_sent;
    logic stall_burst;

    pressure_temperature_compensation_core DUT (.*);

    ptc_scoreboard checker_inst (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // receiver stall
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_burst)
                m_axis_tready = 1'b1;
            else
                m_axis_tready = ($urandom_range(0, 3) != 0) || ($urandom_range(0, 30) == 0);
            if (!stall_burst && $urandom_range(0, 40) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(10, 100)) @(negedge clk);
            end
        end
    end

    task automatic send_reading(input logic op, input logic [19:0] raw, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g) @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {4'd0, raw};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        readings_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 24'($urandom);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // calibration: nominal with slight random perturbation (0), extreme positive (1), extreme negative (2) or random
    task automatic load_cal(input int mode);
        logic [63:0] r0, r1, r2, r3;
        case (mode)
            0:
            begin
                r0 = {16'd0, 16'hFF9C + 16'($urandom_range(0, 8)), 16'd26435, 16'd27504};
                r1 = {16'd2855, 16'd3024, 16'(-10685),
                    16'd36477 + 16'($urandom_range(0, 99))};
                r2 = {16'(-7) - 16'($urandom_range(0, 10)), 16'd15500, 16'(-7),
                    16'd140};
                r3 = 64'd6000;
            end
            1:
            begin
                r0 = {16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF};
                r1 = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
                r2 = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
                r3 = 64'h7FFF;
            end
            2:
            begin
                r0 = {16'd0, 16'h8000, 16'h8000, 16'h0000};
                r1 = {16'h8000, 16'h8000, 16'h8000, 16'h0000};
                r2 = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
                r3 = 64'hFFFF_FFFF_FFFF_8000;
            end
            default:
            begin
                r0 = {$urandom, $urandom};
                r1 = {$urandom, $urandom};
                r2 = {$urandom, $urandom};
                r3 = {$urandom, $urandom};
                if ($urandom_range(0, 3) == 0)
                    r1[15:0] = 16'($urandom_range(0, 3));
            end
        endcase
        write_cfg(REG_TCAL, r0);
        write_cfg(REG_PLOW, r1);
        write_cfg(REG_PHIGH, r2);
        write_cfg(REG_P9, r3);
    endtask

    initial
    begin
        int n;
        logic op;
        stall_burst = 1'b0;
        readings_sent = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TEMP;
        cfg_we = 1'b0;
        cfg_index = REG_TCAL;
        cfg_data = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // pressure with reset calibration: divide by zero, fine temp still zero
        send_reading(OP_PRESS, 20'h80000, 1'b0);
        send_reading(OP_TEMP, 20'h00000, 1'b0);
        drain();
        load_cal(0);
        send_reading(OP_PRESS, 20'h655A0, 1'b0);
        send_reading(OP_TEMP, 20'h7E8C0, 1'b0);
        send_reading(OP_PRESS, 20'h655A0, 1'b0);
        send_reading(OP_PRESS, 20'h00000, 1'b0);
        send_reading(OP_PRESS, 20'hFFFFF, 1'b0);
        send_reading(OP_TEMP, 20'hFFFFF, 1'b0);
        send_reading(OP_PRESS, 20'hAAAAA, 1'b0);
        send_reading(OP_TEMP, 20'h55555, 1'b0);
        send_reading(OP_PRESS, 20'h55555, 1'b0);
        drain();
        for (int m = 1; m <= 2; m++)
        begin
            load_cal(m);
            send_reading(OP_TEMP, 20'h00000, 1'b0);
            send_reading(OP_PRESS, 20'hFFFFF, 1'b0);
            send_reading(OP_TEMP, 20'hFFFFF, 1'b0);
            send_reading(OP_PRESS, 20'h00000, 1'b0);
            drain();
        end
        // P9 write with upper junk bits (overwritten by load_cal before any reading)
        write_cfg(REG_P9, 64'hDEAD_BEEF_0000_1234);

        for (int ph = 0; ph < 16; ph++)
        begin
            load_cal(ph % 4 == 0 ? 0 : 3);
            stall_burst = (ph % 5 == 4);
            n = 100;
            for (int i = 0; i < n; i++)
            begin
                op = (i % 2 == 0) ? OP_TEMP : OP_PRESS;
                if ($urandom_range(0, 4) == 0)
                    op = 1'($urandom_range(0, 1));
                send_reading(op, ($urandom_range(0, 3) == 0) ? 20'($urandom) :
                    20'($urandom_range(20'h40000, 20'h90000)), !stall_burst);
                if ($urandom_range(0, 150) == 0)
                    while (pending != 0)
                        @(negedge clk);
            end
            drain();
        end
        stall_burst = 1'b0;
        $display("%0d readings sent, %0d results checked, %0d divide-by-zero flags",
            readings_sent, results_seen, div_zero_seen);
        $display("covered nominal, extreme and random calibration sets with random stalls");
        if (errors == 0 && pending == 0)
            $display("pressure_temperature_compensation_core test passed");
        else
            $display("pressure_temperature_compensation_core test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("pressure_temperature_compensation_core test failed");
        $finish;
    end
endmodule
